>>> hdl/quadrature_position_velocity_unit_macros.svh
// assertion macros for the quadrature position and velocity unit
// used by the top level only, no other dependencies
`ifndef QUADRATURE_POSITION_VELOCITY_UNIT_MACROS_SVH
`define QUADRATURE_POSITION_VELOCITY_UNIT_MACROS_SVH

// condition must hold whenever the antecedent holds
`define QPV_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qpv: implication check failed");

// condition must hold in the cycle after the antecedent
`define QPV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qpv: next-cycle check failed");

`endif

>>> hdl/qpv_pkg.sv
// shared types, constants and the 4x step table of the quadrature unit
// no dependencies
`default_nettype none

package qpv_pkg;

  localparam int PosW     = 32;               // position, velocity, acceleration width
  localparam int TimeW    = 32;               // millisecond time width
  localparam int DtW      = 16;               // elapsed time kept as signed 16 bits
  localparam int DenW     = DtW - 1;          // positive elapsed time magnitude
  localparam int QDepth   = 2;                // item queue between front and back
  localparam int QIdxW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);
  localparam int DivSteps = PosW;             // one quotient bit per cycle
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic {
    OP_PIN    = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  // classified item as it travels through the queue
  typedef struct packed {
    op_e              op;
    logic [1:0]       pins;    // {b, a}
    logic [TimeW-1:0] time_ms;
  } item_t;

  // request to the shared divider: sign, dividend magnitude, divisor
  typedef struct packed {
    logic            neg;
    logic [PosW-1:0] mag;
    logic [DenW-1:0] den;
  } div_req_t;

  // signed step for the transition {prev, now}
  function automatic logic signed [1:0] step_of(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default:                  s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> hdl/qpv_front.sv
// front end: accepts items, classifies them and holds them in a short queue
// depends on qpv_pkg
`default_nettype none

module qpv_front import qpv_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic             cmd_i,
  input  wire logic             pin_a_i,
  input  wire logic             pin_b_i,
  input  wire logic [TimeW-1:0] time_ms_i,
  output logic                  item_valid_o,
  input  wire logic             item_ready_i,
  output item_t                 item_o
);

  item_t            mem_q [QDepth];
  logic [QIdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             wr_en, rd_en;
  item_t            item_in;

  // classify: pin samples drop the time, updates drop the pins
  always_comb begin
    item_in = '0;
    if (cmd_i) begin
      item_in.op      = OP_UPDATE;
      item_in.time_ms = time_ms_i;
    end else begin
      item_in.op   = OP_PIN;
      item_in.pins = {pin_b_i, pin_a_i};
    end
  end

  assign full         = (cnt_q == QCntW'(QDepth));
  assign wr_en        = push && !full;
  assign item_valid_o = (cnt_q != '0);
  assign rd_en        = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == QIdxW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == QIdxW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/qpv_div.sv
// shared restoring divider, one quotient bit per cycle, truncates toward zero
// depends on qpv_pkg
`default_nettype none

module qpv_div import qpv_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  div_req_t       req_i,
  output logic           busy_o,
  output logic           done_o,
  output logic [PosW-1:0] quo_o
);

  logic               busy_q, done_q, neg_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DenW-1:0]    den_q, rem_q;
  logic [PosW-1:0]    dvd_q;
  logic [DenW:0]      trial;
  logic               ge;

  // trial subtract of the next dividend bit
  assign trial = {rem_q, dvd_q[PosW-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        neg_q  <= req_i.neg;
        den_q  <= req_i.den;
        dvd_q  <= req_i.mag;
        rem_q  <= '0;
        cnt_q  <= DivCntW'(DivSteps - 1);
      end else if (busy_q) begin
        rem_q <= ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
        dvd_q <= {dvd_q[PosW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = neg_q ? (~dvd_q + 1'b1) : dvd_q;

endmodule

`default_nettype wire

>>> hdl/qpv_back.sv
// back end: position count, update sequencer around the divider, result register
// depends on qpv_pkg
`default_nettype none

module qpv_back import qpv_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             item_valid_i,
  output logic                  item_ready_o,
  input  item_t                 item_i,
  output logic                  div_start_o,
  output div_req_t              div_req_o,
  input  wire logic             div_done_i,
  input  wire logic [PosW-1:0]  div_quo_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic signed [PosW-1:0] position_o,
  output logic signed [PosW-1:0] velocity_o,
  output logic signed [PosW-1:0] acceleration_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPEED,
    ST_ACCEL_GO,
    ST_ACCEL
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       prev_pins_q, prev_pins_d;
  logic [PosW-1:0]  count_q, count_d, cnt_upd_q, cnt_upd_d;
  logic [TimeW-1:0] t_upd_q, t_upd_d, t_new_q, t_new_d;
  logic [PosW-1:0]  speed_q, speed_d, prev_speed_q, prev_speed_d, accel_q, accel_d;
  logic [DenW-1:0]  den_q, den_d;
  logic             out_valid_q, out_valid_d;
  logic [PosW-1:0]  out_pos_q, out_pos_d, out_vel_q, out_vel_d, out_acc_q, out_acc_d;

  logic             fire;
  logic [PosW-1:0]  change;
  logic [TimeW-1:0] elapsed;
  logic [DtW-1:0]   dt;
  logic [PosW-1:0]  abs_speed, abs_prev;
  logic [PosW:0]    diff;
  logic [PosW:0]    diff_mag;
  logic signed [1:0] step;

  assign item_ready_o = (state_q == ST_IDLE) && (!out_valid_q || pop);
  assign fire         = item_valid_i && item_ready_o;

  // update arithmetic
  assign change    = count_q - cnt_upd_q;
  assign elapsed   = item_i.time_ms - t_upd_q;
  assign dt        = elapsed[DtW-1:0];
  assign abs_speed = speed_q[PosW-1] ? (~speed_q + 1'b1) : speed_q;
  assign abs_prev  = prev_speed_q[PosW-1] ? (~prev_speed_q + 1'b1) : prev_speed_q;
  assign diff      = {1'b0, abs_speed} - {1'b0, abs_prev};
  assign diff_mag  = diff[PosW] ? (~diff + 1'b1) : diff;
  assign step      = step_of({prev_pins_q, item_i.pins});

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    prev_pins_d  = prev_pins_q;
    count_d      = count_q;
    cnt_upd_d    = cnt_upd_q;
    t_upd_d      = t_upd_q;
    t_new_d      = t_new_q;
    speed_d      = speed_q;
    prev_speed_d = prev_speed_q;
    accel_d      = accel_q;
    den_d        = den_q;
    out_valid_d  = out_valid_q && !pop;
    out_pos_d    = out_pos_q;
    out_vel_d    = out_vel_q;
    out_acc_d    = out_acc_q;
    div_start_o  = 1'b0;
    div_req_o    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          if (item_i.op == OP_PIN) begin
            if (item_i.pins != prev_pins_q) begin
              count_d     = count_q + {{(PosW-2){step[1]}}, step};
              prev_pins_d = item_i.pins;
            end
            out_valid_d = 1'b1;
            out_pos_d   = count_d;
            out_vel_d   = speed_q;
            out_acc_d   = accel_q;
          end else begin
            cnt_upd_d = count_q;
            if (dt != '0 && !dt[DtW-1]) begin
              den_d         = dt[DenW-1:0];
              t_new_d       = item_i.time_ms;
              div_start_o   = 1'b1;
              div_req_o.neg = change[PosW-1];
              div_req_o.mag = change[PosW-1] ? (~change + 1'b1) : change;
              div_req_o.den = dt[DenW-1:0];
              state_d       = ST_SPEED;
            end else begin
              out_valid_d = 1'b1;
              out_pos_d   = count_q;
              out_vel_d   = speed_q;
              out_acc_d   = accel_q;
            end
          end
        end
      end
      ST_SPEED: begin
        if (div_done_i) begin
          speed_d = div_quo_i;
          state_d = ST_ACCEL_GO;
        end
      end
      ST_ACCEL_GO: begin
        div_start_o   = 1'b1;
        div_req_o.neg = diff[PosW];
        div_req_o.mag = diff_mag[PosW-1:0];
        div_req_o.den = den_q;
        state_d       = ST_ACCEL;
      end
      ST_ACCEL: begin
        if (div_done_i) begin
          accel_d      = div_quo_i;
          prev_speed_d = speed_q;
          t_upd_d      = t_new_q;
          out_valid_d  = 1'b1;
          out_pos_d    = count_q;
          out_vel_d    = speed_q;
          out_acc_d    = div_quo_i;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_pins_q  <= '0;
      count_q      <= '0;
      cnt_upd_q    <= '0;
      t_upd_q      <= '0;
      t_new_q      <= '0;
      speed_q      <= '0;
      prev_speed_q <= '0;
      accel_q      <= '0;
      den_q        <= '0;
      out_valid_q  <= 1'b0;
      out_pos_q    <= '0;
      out_vel_q    <= '0;
      out_acc_q    <= '0;
    end else begin
      state_q      <= state_d;
      prev_pins_q  <= prev_pins_d;
      count_q      <= count_d;
      cnt_upd_q    <= cnt_upd_d;
      t_upd_q      <= t_upd_d;
      t_new_q      <= t_new_d;
      speed_q      <= speed_d;
      prev_speed_q <= prev_speed_d;
      accel_q      <= accel_d;
      den_q        <= den_d;
      out_valid_q  <= out_valid_d;
      out_pos_q    <= out_pos_d;
      out_vel_q    <= out_vel_d;
      out_acc_q    <= out_acc_d;
    end
  end

  assign empty          = !out_valid_q;
  assign position_o     = out_pos_q;
  assign velocity_o     = out_vel_q;
  assign acceleration_o = out_acc_q;

endmodule

`default_nettype wire

>>> hdl/quadrature_position_velocity_unit.sv
// Quadrature position counter with velocity and acceleration estimate.
// Input side is a queue: drive cmd_i, pin_a_i, pin_b_i, time_ms_i and raise
// push; the word is taken at a clock edge where push is high and full is low.
// cmd_i low is a pin sample (4x decode into a wrapping 32-bit count), cmd_i
// high is an update event that recomputes velocity and acceleration when the
// elapsed time, as signed 16 bits, is positive.
// Result side is a queue: while empty is low, position_o, velocity_o and
// acceleration_o hold the oldest result word; it is taken on a clock edge
// with pop high. Every input word yields exactly one result word.
// A pin sample or an update with non-positive elapsed time reaches the result
// ports through the two-entry queue and the result register; a full update
// makes two passes through the shared divider (one quotient bit per cycle)
// plus handoff. Pin samples sustain one word per cycle while pop stays high.
// A two-entry queue decouples the input from the execution, so words keep
// coming in while a result waits; when pop stays low the result register
// holds, execution stalls and full rises once the queue is taken up.
// Reset (rst_ni low, asynchronous) clears the count, velocity, acceleration,
// stored pin state and update reference, and empties both queues.
// depends on qpv_pkg, qpv_front, qpv_div, qpv_back and the macros header
`default_nettype none

`include "quadrature_position_velocity_unit_macros.svh"

module quadrature_position_velocity_unit import qpv_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              cmd_i,
  input  wire logic              pin_a_i,
  input  wire logic              pin_b_i,
  input  wire logic [TimeW-1:0]  time_ms_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic signed [PosW-1:0] position_o,
  output logic signed [PosW-1:0] velocity_o,
  output logic signed [PosW-1:0] acceleration_o
);

  logic            item_valid, item_ready;
  item_t           item;
  logic            div_start, div_busy, div_done;
  div_req_t        div_req;
  logic [PosW-1:0] div_quo;

  // accept and classify
  qpv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cmd_i        (cmd_i),
    .pin_a_i      (pin_a_i),
    .pin_b_i      (pin_b_i),
    .time_ms_i    (time_ms_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // shared divider
  qpv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // execute and hold results
  qpv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_ready_o   (item_ready),
    .item_i         (item),
    .div_start_o    (div_start),
    .div_req_o      (div_req),
    .div_done_i     (div_done),
    .div_quo_i      (div_quo),
    .empty          (empty),
    .pop            (pop),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o)
  );

  // divider is only started when it is free
  `QPV_ASSERT_IMPLIES(a_div_start_free, clk_i, rst_ni, div_start, !div_busy)
  // no result word waits while a division runs
  `QPV_ASSERT_IMPLIES(a_div_busy_empty, clk_i, rst_ni, div_busy, empty)
  // a new word is never taken during a division
  `QPV_ASSERT_IMPLIES(a_no_take_busy, clk_i, rst_ni, item_valid && item_ready, !div_busy)
  // a divider start is followed by a running division
  `QPV_ASSERT_NEXT(a_div_runs, clk_i, rst_ni, div_start, div_busy)

endmodule

`default_nettype wire
